@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the framer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif

`endif

@@ hdl/asqbf_pkg.sv @@
// ---------------------------------------------------------------------------
// asqbf_pkg
// Shared types and constants of the ADC sample byte framer.
// ---------------------------------------------------------------------------
`default_nettype none

package asqbf_pkg;

  localparam int unsigned AdcW      = 16;
  localparam int unsigned LenW      = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [LenW-1:0] LenReset = 16'd2048;

  localparam logic [ByteW-1:0] SyncHi = 8'hAA;
  localparam logic [ByteW-1:0] SyncLo = 8'h55;

  // byte slots of one request, in emission order
  localparam int unsigned StepW = 3;
  localparam logic [StepW-1:0] StepHdrA   = 3'd0;
  localparam logic [StepW-1:0] StepHdrB   = 3'd1;
  localparam logic [StepW-1:0] StepLenHi  = 3'd2;
  localparam logic [StepW-1:0] StepLenLo  = 3'd3;
  localparam logic [StepW-1:0] StepSmpHi  = 3'd4;
  localparam logic [StepW-1:0] StepSmpLo  = 3'd5;
  localparam logic [StepW-1:0] StepTailA  = 3'd6;
  localparam logic [StepW-1:0] StepTailB  = 3'd7;

  typedef struct packed {
    logic [15:0]     sample;  // Q15 value
    logic [LenW-1:0] len;     // block length for the header
    logic            first;   // header precedes the sample
    logic            last;    // tail follows the sample
  } entry_t;

endpackage

`default_nettype wire

@@ hdl/asqbf_front.sv @@
// ---------------------------------------------------------------------------
// asqbf_front
// Scales a raw ADC word to Q15, tracks the frame position, builds requests.
// ---------------------------------------------------------------------------
`default_nettype none

module asqbf_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [asqbf_pkg::LenW-1:0]   cfg_wdata,
  input  wire logic                         in_accept,
  input  wire logic [asqbf_pkg::AdcW-1:0]   adc_word,
  output asqbf_pkg::entry_t                 entry
);

  logic [asqbf_pkg::LenW-1:0] len_r, len_nxt;
  logic [asqbf_pkg::LenW-1:0] idx_r, idx_nxt;
  logic [asqbf_pkg::LenW-1:0] last_pos;

  logic signed [12:0] cent;
  logic signed [27:0] prod;
  logic signed [27:0] adj;
  logic        [16:0] quo;
  logic        [15:0] q15;

  // (c * 32767) / 2048, rounded toward zero
  always_comb begin
    cent = $signed({1'b0, adc_word[11:0]}) - 13'sd2048;
    prod = $signed({cent, 15'b0}) - $signed({{15{cent[12]}}, cent});
    adj  = prod + (prod[27] ? 28'sd2047 : 28'sd0);
    quo  = adj[27:11];
    if (quo[16] != quo[15]) begin
      q15 = quo[16] ? 16'h8000 : 16'h7FFF;
    end else begin
      q15 = quo[15:0];
    end
  end

  assign last_pos = len_r - 16'd1;

  always_comb begin
    entry.sample = q15;
    entry.len    = len_r;
    entry.first  = (idx_r == '0);
    entry.last   = (idx_r >= last_pos);
  end

  always_comb begin
    len_nxt = cfg_we ? cfg_wdata : len_r;
    idx_nxt = idx_r;
    if (in_accept) begin
      idx_nxt = entry.last ? '0 : idx_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= asqbf_pkg::LenReset;
      idx_r <= '0;
    end else begin
      len_r <= len_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/asqbf_fifo.sv @@
// ---------------------------------------------------------------------------
// asqbf_fifo
// Small register queue between the front and the byte sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module asqbf_fifo #(
  parameter int unsigned DEPTH = asqbf_pkg::QueueDepthDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire asqbf_pkg::entry_t wr_entry,
  output logic                   full,
  input  wire logic              pop,
  output logic                   rd_valid,
  output asqbf_pkg::entry_t      rd_entry
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntMax = CntW'(DEPTH);

  asqbf_pkg::entry_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full     = (cnt_r == CntMax);
  assign rd_valid = (cnt_r != '0);
  assign rd_entry = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrMax) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrMax) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  `ASSERT_NEVER(a_cnt_overflow, cnt_r > CntMax)
  `ASSERT_CLK(a_cnt_track, (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))

endmodule

`default_nettype wire

@@ hdl/asqbf_back.sv @@
// ---------------------------------------------------------------------------
// asqbf_back
// Byte sequencer: walks header, sample and tail slots into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module asqbf_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire asqbf_pkg::entry_t             q_entry,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [asqbf_pkg::ByteW-1:0]        out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast
);

  asqbf_pkg::entry_t cur_r, cur_nxt;
  logic                        cur_valid_r, cur_valid_nxt;
  logic [asqbf_pkg::StepW-1:0] step_r, step_nxt;

  logic                        ovalid_r, ovalid_nxt;
  logic [asqbf_pkg::ByteW-1:0] obyte_r, obyte_nxt;
  logic                        oend_r, oend_nxt;
  logic                        olast_r, olast_nxt;

  logic                        adv;
  logic                        cur_done;
  logic [asqbf_pkg::ByteW-1:0] slot_byte;

  assign adv      = !ovalid_r || out_tready;
  assign cur_done = cur_valid_r &&
                    ((step_r == asqbf_pkg::StepSmpLo && !cur_r.last) ||
                     (step_r == asqbf_pkg::StepTailB));
  assign q_pop    = adv && (!cur_valid_r || cur_done) && q_valid;

  always_comb begin
    case (step_r)
      asqbf_pkg::StepHdrA:  slot_byte = asqbf_pkg::SyncHi;
      asqbf_pkg::StepHdrB:  slot_byte = asqbf_pkg::SyncLo;
      asqbf_pkg::StepLenHi: slot_byte = cur_r.len[15:8];
      asqbf_pkg::StepLenLo: slot_byte = cur_r.len[7:0];
      asqbf_pkg::StepSmpHi: slot_byte = cur_r.sample[15:8];
      asqbf_pkg::StepSmpLo: slot_byte = cur_r.sample[7:0];
      asqbf_pkg::StepTailA: slot_byte = asqbf_pkg::SyncLo;
      default:              slot_byte = asqbf_pkg::SyncHi;
    endcase
  end

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    ovalid_nxt    = ovalid_r;
    obyte_nxt     = obyte_r;
    oend_nxt      = oend_r;
    olast_nxt     = olast_r;
    if (adv) begin
      ovalid_nxt = cur_valid_r;
      obyte_nxt  = slot_byte;
      oend_nxt   = (step_r == asqbf_pkg::StepTailB);
      olast_nxt  = cur_done;
      if (cur_valid_r && !cur_done) begin
        step_nxt = step_r + 1'b1;
      end else if (q_pop) begin
        cur_nxt       = q_entry;
        cur_valid_nxt = 1'b1;
        step_nxt      = q_entry.first ? asqbf_pkg::StepHdrA : asqbf_pkg::StepSmpHi;
      end else begin
        cur_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      ovalid_r    <= 1'b0;
      step_r      <= asqbf_pkg::StepHdrA;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      ovalid_r    <= ovalid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    obyte_r <= obyte_nxt;
    oend_r  <= oend_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = obyte_r;
  assign out_tuser  = oend_r;
  assign out_tlast  = olast_r;

  `ASSERT_CLK(a_end_is_last, (ovalid_r && oend_r) |-> olast_r)
  `ASSERT_CLK(a_tail_needs_last,
              (cur_valid_r && step_r == asqbf_pkg::StepTailA) |-> cur_r.last)
  `ASSERT_CLK(a_hdr_needs_first,
              (cur_valid_r && step_r == asqbf_pkg::StepLenLo) |-> cur_r.first)

endmodule

`default_nettype wire

@@ hdl/adc_sample_q15_byte_framer.sv @@
// ---------------------------------------------------------------------------
// adc_sample_q15_byte_framer
// Raw ADC words in, framed Q15 byte stream out.
// ---------------------------------------------------------------------------
//  Channel | Dir | Handshake          | Payload
//  in_     | in  | in_tvalid/tready   | in_tdata[15:0] = adc_word
//  out_    | out | out_tvalid/tready  | out_tdata = out_byte, out_tuser = frame_end,
//          |     |                    | out_tlast = run_last
//  cfg_    | in  | cfg_we             | cfg_wdata[15:0] = block_length
//
//  One byte leaves per cycle from the output register while out_tready is high;
//  a plain sample is 2 bytes, 6 with a frame header, 4 with a tail, 8 with both.
//  Sample scaling happens on the input request in the accept cycle and the
//  request is queued; the sequencer pulls the next request as the previous
//  one's last byte is loaded, leaving no bubble between samples.
//  Output stalls fill the queue; in_tready drops only when it is full.
//  Reset (rst_n low, synchronous) empties the queue and output register,
//  restarts the frame and sets block_length to 2048.
// ---------------------------------------------------------------------------
`default_nettype none

module adc_sample_q15_byte_framer #(
  parameter int unsigned QUEUE_DEPTH = asqbf_pkg::QueueDepthDef
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration
  input  wire logic                         cfg_we,
  input  wire logic [asqbf_pkg::LenW-1:0]   cfg_wdata,   // block_length
  // sample input
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [asqbf_pkg::AdcW-1:0]   in_tdata,    // [15:0] adc_word
  // byte output
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [asqbf_pkg::ByteW-1:0]       out_tdata,   // [7:0] out_byte
  output logic                              out_tuser,   // [0] frame_end
  output logic                              out_tlast    // run_last
);

  asqbf_pkg::entry_t front_entry;
  asqbf_pkg::entry_t q_entry;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic              in_accept;

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  // scaling and frame position tracking
  asqbf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_accept (in_accept),
    .adc_word  (in_tdata),
    .entry     (front_entry)
  );

  // decouples the input from output stalls
  asqbf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept),
    .wr_entry (front_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_entry (q_entry)
  );

  // byte sequencer with registered output
  asqbf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
